// ----- rtl/tfr_pkg.sv -----
// shared types and constants for the four-register execute unit
`default_nettype none

package tfr_pkg;

   localparam int OP_WIDTH      = 4;
   localparam int REG_IDX_WIDTH = 2;
   localparam int ADDR_WIDTH    = 8;
   localparam int VALUE_WIDTH   = 32;
   localparam int PC_WIDTH      = 11;
   localparam int PLEN_WIDTH    = 10;

   localparam logic [PC_WIDTH-1:0]   PC_STEP    = 11'd4;
   localparam logic [PLEN_WIDTH-1:0] PLEN_RESET = 10'd1023;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_ADD        = 4'd0,
      OP_SUB        = 4'd1,
      OP_LOAD       = 4'd2,
      OP_STORE      = 4'd3,
      OP_JUMP       = 4'd4,
      OP_JZ         = 4'd5,
      OP_JNZ        = 4'd6,
      OP_HALT       = 4'd7,
      OP_PRESET_MEM = 4'd8,
      OP_PRESET_REG = 4'd9
   } op_type;

   // write strobes and targets from the execute logic to the stores
   typedef struct packed {
      logic                     rf_we;
      logic [REG_IDX_WIDTH-1:0] rf_idx;
      logic                     mem_we;
      logic [ADDR_WIDTH-1:0]    mem_addr;
   } wr_ctrl_type;

endpackage

`default_nettype wire

// ----- rtl/tfr_if.sv -----
// valid/ready channel interfaces for instructions, results and the csr write
`default_nettype none

interface tfr_req_if import tfr_pkg::*; ();
   logic                            valid;
   logic                            ready;
   logic [OP_WIDTH-1:0]             op;
   logic [REG_IDX_WIDTH-1:0]        first_reg;
   logic [REG_IDX_WIDTH-1:0]        second_reg;
   logic [ADDR_WIDTH-1:0]           address;
   logic signed [VALUE_WIDTH-1:0]   preset_value;

   modport source (output valid, op, first_reg, second_reg, address, preset_value,
                   input ready);
   modport sink   (input valid, op, first_reg, second_reg, address, preset_value,
                   output ready);
endinterface

interface tfr_rsp_if import tfr_pkg::*; ();
   logic                            valid;
   logic                            ready;
   logic [PC_WIDTH-1:0]             pc_after;
   logic                            stopped;
   logic signed [VALUE_WIDTH-1:0]   value_written;

   modport source (output valid, pc_after, stopped, value_written, input ready);
   modport sink   (input valid, pc_after, stopped, value_written, output ready);
endinterface

interface tfr_csr_if import tfr_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [PLEN_WIDTH-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/tfr_regfile.sv -----
// register file with registered read ports and write bypass
`default_nettype none

module tfr_regfile import tfr_pkg::*; #(
   parameter int REGISTER_COUNT = 4,
   parameter int DATA_WIDTH     = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rd_en,
   input  logic [REG_IDX_WIDTH-1:0] rd_idx_a,
   input  logic [REG_IDX_WIDTH-1:0] rd_idx_b,
   input  wr_ctrl_type              wr,
   input  logic [DATA_WIDTH-1:0]    wr_data,
   output logic [DATA_WIDTH-1:0]    rd_a_ff,
   output logic [DATA_WIDTH-1:0]    rd_b_ff
);

   localparam int RF_DEPTH = (REGISTER_COUNT < 4) ? REGISTER_COUNT : 4;
   localparam int RW       = $clog2(RF_DEPTH);

   logic [DATA_WIDTH-1:0] regs_ff [RF_DEPTH];
   logic [DATA_WIDTH-1:0] rd_a_in;
   logic [DATA_WIDTH-1:0] rd_b_in;

   always_comb begin
      if (wr.rf_we && wr.rf_idx == rd_idx_a) begin
         rd_a_in = wr_data;
      end else if (32'(rd_idx_a) < RF_DEPTH) begin
         rd_a_in = regs_ff[rd_idx_a[RW-1:0]];
      end else begin
         rd_a_in = '0;
      end
      if (wr.rf_we && wr.rf_idx == rd_idx_b) begin
         rd_b_in = wr_data;
      end else if (32'(rd_idx_b) < RF_DEPTH) begin
         rd_b_in = regs_ff[rd_idx_b[RW-1:0]];
      end else begin
         rd_b_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RF_DEPTH; i++) begin
            regs_ff[i] <= '0;
         end
      end else if (wr.rf_we) begin
         regs_ff[wr.rf_idx[RW-1:0]] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= rd_a_in;
         rd_b_ff <= rd_b_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/tfr_dmem.sv -----
// data memory with per-word valid bits, registered read and write bypass
`default_nettype none

module tfr_dmem import tfr_pkg::*; #(
   parameter int MEMORY_WORDS = 256,
   parameter int DATA_WIDTH   = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   input  wr_ctrl_type           wr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   output logic [DATA_WIDTH-1:0] rd_data_ff
);

   localparam int MEM_DEPTH = (MEMORY_WORDS < 256) ? MEMORY_WORDS : 256;
   localparam int AW        = $clog2(MEM_DEPTH);

   logic [DATA_WIDTH-1:0] mem_ff [MEM_DEPTH];
   logic [MEM_DEPTH-1:0]  written_ff;
   logic                  rd_ok;
   logic                  bypass;

   assign rd_ok  = 32'(rd_addr) < MEM_DEPTH;
   assign bypass = wr.mem_we && wr.mem_addr == rd_addr;

   // never-written words read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr.mem_we) begin
         written_ff[wr.mem_addr[AW-1:0]] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.mem_we) begin
         mem_ff[wr.mem_addr[AW-1:0]] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (bypass) begin
            rd_data_ff <= wr_data;
         end else if (rd_ok && written_ff[rd_addr[AW-1:0]]) begin
            rd_data_ff <= mem_ff[rd_addr[AW-1:0]];
         end else begin
            rd_data_ff <= '0;
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/tfr_exec.sv -----
// instruction execute logic: alu, branch decision, next counter and write select
`default_nettype none

module tfr_exec import tfr_pkg::*; #(
   parameter int MEMORY_WORDS   = 256,
   parameter int REGISTER_COUNT = 4,
   parameter int DATA_WIDTH     = 32
) (
   input  logic [OP_WIDTH-1:0]           op,
   input  logic [REG_IDX_WIDTH-1:0]      first_reg,
   input  logic [REG_IDX_WIDTH-1:0]      second_reg,
   input  logic [ADDR_WIDTH-1:0]         address,
   input  logic signed [VALUE_WIDTH-1:0] preset_value,
   input  logic [DATA_WIDTH-1:0]         rf_a,
   input  logic [DATA_WIDTH-1:0]         rf_b,
   input  logic [DATA_WIDTH-1:0]         mem_rd,
   input  logic [PC_WIDTH-1:0]           pc,
   input  logic                          running,
   input  logic [PLEN_WIDTH-1:0]         plen,
   output logic [PC_WIDTH-1:0]           pc_next,
   output logic                          running_next,
   output wr_ctrl_type                   wr,
   output logic [DATA_WIDTH-1:0]         wr_data,
   output logic                          stopped,
   output logic signed [VALUE_WIDTH-1:0] value_written
);

   logic                  r1_ok;
   logic                  r2_ok;
   logic                  a_ok;
   logic                  halted_before;
   logic                  advance;
   logic [DATA_WIDTH-1:0] pv;
   logic [DATA_WIDTH-1:0] written;

   assign r1_ok = 32'(first_reg) < REGISTER_COUNT;
   assign r2_ok = 32'(second_reg) < REGISTER_COUNT;
   assign a_ok  = 32'(address) < MEMORY_WORDS;
   assign pv    = DATA_WIDTH'(preset_value);

   assign halted_before = !running || pc >= {1'b0, plen};

   always_comb begin
      pc_next      = pc;
      running_next = running;
      wr           = '0;
      wr.rf_idx    = first_reg;
      wr.mem_addr  = address;
      wr_data      = '0;
      written      = '0;
      advance      = 1'b0;

      if (op_type'(op) == OP_PRESET_MEM) begin
         if (a_ok) begin
            wr.mem_we = 1'b1;
            wr_data   = pv;
            written   = pv;
         end
      end else if (op_type'(op) == OP_PRESET_REG) begin
         if (r1_ok) begin
            wr.rf_we = 1'b1;
            wr_data  = pv;
            written  = pv;
         end
      end else if (!halted_before) begin
         advance = 1'b1;
         unique case (op_type'(op))
            OP_ADD, OP_SUB: begin
               if (r1_ok && r2_ok) begin
                  wr.rf_we = 1'b1;
                  wr_data  = (op_type'(op) == OP_ADD) ? rf_a + rf_b : rf_a - rf_b;
                  written  = wr_data;
               end
            end
            OP_LOAD: begin
               if (r1_ok && a_ok) begin
                  wr.rf_we = 1'b1;
                  wr_data  = mem_rd;
                  written  = mem_rd;
               end
            end
            OP_STORE: begin
               if (r1_ok && a_ok) begin
                  wr.mem_we = 1'b1;
                  wr_data   = rf_a;
                  written   = rf_a;
               end
            end
            OP_JUMP: begin
               if (a_ok) begin
                  pc_next = PC_WIDTH'(address);
                  advance = 1'b0;
               end
            end
            OP_JZ, OP_JNZ: begin
               if (r1_ok && a_ok && ((op_type'(op) == OP_JZ) == (rf_a == '0))) begin
                  pc_next = PC_WIDTH'(address);
                  advance = 1'b0;
               end
            end
            default: begin
               // halt and unknown codes
               running_next = 1'b0;
               advance      = 1'b0;
            end
         endcase
      end

      if (advance) begin
         pc_next = pc + PC_STEP;
      end
   end

   assign stopped       = !running_next || pc_next >= {1'b0, plen};
   assign value_written = VALUE_WIDTH'(written);

endmodule

`default_nettype wire

// ----- rtl/toy_four_register_cpu_execute_unit.sv -----
// an accepted beat is registered in the operand stage and then in the result register,
//   which drives rsp; a result not taken on rsp holds the operand stage and the input
// throughput: one instruction per cycle while rsp takes its beats, set by the single
//   execute pass between the operand register and the result register
// operands are read from the register file and data memory at the accepting edge,
//   bypassed from the instruction executing at that same edge
// reset (synchronous, active high) empties both stages, clears registers, pc and memory
//   valid bits, sets running, and loads program_length with 1023; no clearing pass
`default_nettype none

module toy_four_register_cpu_execute_unit import tfr_pkg::*; #(
   parameter int MEMORY_WORDS   = 256,
   parameter int REGISTER_COUNT = 4,
   parameter int DATA_WIDTH     = 32
) (
   input  logic       clock,
   input  logic       reset,
   tfr_req_if.sink    req_chan,
   tfr_rsp_if.source  rsp_chan,
   tfr_csr_if.sink    csr_chan
);

   // operand stage: instruction fields, read data sits in the store modules
   logic                          s1_valid_ff;
   logic [OP_WIDTH-1:0]           s1_op_ff;
   logic [REG_IDX_WIDTH-1:0]      s1_first_reg_ff;
   logic [REG_IDX_WIDTH-1:0]      s1_second_reg_ff;
   logic [ADDR_WIDTH-1:0]         s1_address_ff;
   logic signed [VALUE_WIDTH-1:0] s1_preset_value_ff;

   // result stage
   logic                          out_valid_ff;
   logic [PC_WIDTH-1:0]           out_pc_after_ff;
   logic                          out_stopped_ff;
   logic signed [VALUE_WIDTH-1:0] out_value_written_ff;

   // architectural state
   logic [PC_WIDTH-1:0]           pc_ff;
   logic                          running_ff;
   logic [PLEN_WIDTH-1:0]         plen_ff;

   logic                          accept;
   logic                          s1_fire;

   logic [DATA_WIDTH-1:0]         rf_a;
   logic [DATA_WIDTH-1:0]         rf_b;
   logic [DATA_WIDTH-1:0]         mem_rd;
   logic [PC_WIDTH-1:0]           pc_in;
   logic                          running_in;
   wr_ctrl_type                   wr_raw;
   wr_ctrl_type                   wr_gated;
   logic [DATA_WIDTH-1:0]         wr_data;
   logic                          stopped_in;
   logic signed [VALUE_WIDTH-1:0] value_written_in;

   // the operand stage moves on when the result register is empty or being drained
   assign s1_fire          = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready   = !s1_valid_ff || s1_fire;
   assign accept           = req_chan.valid && req_chan.ready;
   assign csr_chan.ready   = 1'b1;

   // stores only change when the executing beat leaves the operand stage
   always_comb begin
      wr_gated        = wr_raw;
      wr_gated.rf_we  = wr_raw.rf_we && s1_fire;
      wr_gated.mem_we = wr_raw.mem_we && s1_fire;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff           <= req_chan.op;
         s1_first_reg_ff    <= req_chan.first_reg;
         s1_second_reg_ff   <= req_chan.second_reg;
         s1_address_ff      <= req_chan.address;
         s1_preset_value_ff <= req_chan.preset_value;
      end
   end

   tfr_regfile #(
      .REGISTER_COUNT (REGISTER_COUNT),
      .DATA_WIDTH     (DATA_WIDTH)
   ) u_regfile (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_idx_a (req_chan.first_reg),
      .rd_idx_b (req_chan.second_reg),
      .wr       (wr_gated),
      .wr_data  (wr_data),
      .rd_a_ff  (rf_a),
      .rd_b_ff  (rf_b)
   );

   tfr_dmem #(
      .MEMORY_WORDS (MEMORY_WORDS),
      .DATA_WIDTH   (DATA_WIDTH)
   ) u_dmem (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (accept),
      .rd_addr    (req_chan.address),
      .wr         (wr_gated),
      .wr_data    (wr_data),
      .rd_data_ff (mem_rd)
   );

   tfr_exec #(
      .MEMORY_WORDS   (MEMORY_WORDS),
      .REGISTER_COUNT (REGISTER_COUNT),
      .DATA_WIDTH     (DATA_WIDTH)
   ) u_exec (
      .op            (s1_op_ff),
      .first_reg     (s1_first_reg_ff),
      .second_reg    (s1_second_reg_ff),
      .address       (s1_address_ff),
      .preset_value  (s1_preset_value_ff),
      .rf_a          (rf_a),
      .rf_b          (rf_b),
      .mem_rd        (mem_rd),
      .pc            (pc_ff),
      .running       (running_ff),
      .plen          (plen_ff),
      .pc_next       (pc_in),
      .running_next  (running_in),
      .wr            (wr_raw),
      .wr_data       (wr_data),
      .stopped       (stopped_in),
      .value_written (value_written_in)
   );

   // pc, running flag and program length
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff      <= '0;
         running_ff <= 1'b1;
         plen_ff    <= PLEN_RESET;
      end else begin
         if (s1_fire) begin
            pc_ff      <= pc_in;
            running_ff <= running_in;
         end
         if (csr_chan.valid) begin
            plen_ff <= csr_chan.data;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         out_pc_after_ff      <= pc_in;
         out_stopped_ff       <= stopped_in;
         out_value_written_ff <= value_written_in;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.pc_after      = out_pc_after_ff;
   assign rsp_chan.stopped       = out_stopped_ff;
   assign rsp_chan.value_written = out_value_written_ff;

endmodule

`default_nettype wire

// ----- rtl/tfr_checker.sv -----
// port-level assertions for the execute unit and their bind
`default_nettype none

module tfr_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);

   // a result beat is held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped before it was taken");

   // the result stage is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   // input stalls only when a result is waiting and not taken
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("req stalled with the result side free");

   // a new result comes from an instruction accepted earlier through the operand stage
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("rsp beat without a matching accepted req beat");

endmodule

bind toy_four_register_cpu_execute_unit tfr_checker u_tfr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready)
);

`default_nettype wire

// ----- tb/toy_four_register_cpu_execute_unit_test.sv -----
// self-checking testbench for the four-register execute unit with an instruction predictor
`timescale 1ns / 1ps

import tfr_pkg::*;

// one decoded instruction as it crosses the req channel
typedef struct packed {
   logic [OP_WIDTH-1:0]      op;
   logic [REG_IDX_WIDTH-1:0] first_reg;
   logic [REG_IDX_WIDTH-1:0] second_reg;
   logic [ADDR_WIDTH-1:0]    address;
   logic [VALUE_WIDTH-1:0]   preset_value;
} instr_type;

// one execute result as it crosses the rsp channel
typedef struct packed {
   logic [PC_WIDTH-1:0]    pc_after;
   logic                   stopped;
   logic [VALUE_WIDTH-1:0] value_written;
} exec_result_type;

// shadow machine state plus the queue of results it predicts
class execute_tracker;
   logic [VALUE_WIDTH-1:0] regs [2**REG_IDX_WIDTH];
   logic [VALUE_WIDTH-1:0] mem [2**ADDR_WIDTH];
   logic [PC_WIDTH-1:0]    pc;
   bit                     running;
   logic [PLEN_WIDTH-1:0]  length;
   exec_result_type        pending_results[$];
   int                     mismatches;
   int                     checked;
   int                     executed;

   function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (mem[i]) mem[i] = '0;
      pc         = '0;
      running    = 1'b1;
      length     = PLEN_RESET;
      mismatches = 0;
      checked    = 0;
      executed   = 0;
   endfunction

   function bit is_stopped();
      return !running || (pc >= {1'b0, length});
   endfunction

   function void set_length(logic [PLEN_WIDTH-1:0] v);
      length = v;
   endfunction

   function void note_instruction(instr_type ins);
      exec_result_type        r;
      logic [VALUE_WIDTH-1:0] written;
      bit                     advance;
      written = '0;
      executed++;
      if (ins.op == OP_PRESET_MEM) begin
         mem[ins.address] = ins.preset_value;
         written = ins.preset_value;
      end else if (ins.op == OP_PRESET_REG) begin
         regs[ins.first_reg] = ins.preset_value;
         written = ins.preset_value;
      end else if (!is_stopped()) begin
         advance = 1'b1;
         case (ins.op)
            OP_ADD: begin
               regs[ins.first_reg] = regs[ins.first_reg] + regs[ins.second_reg];
               written = regs[ins.first_reg];
            end
            OP_SUB: begin
               regs[ins.first_reg] = regs[ins.first_reg] - regs[ins.second_reg];
               written = regs[ins.first_reg];
            end
            OP_LOAD: begin
               regs[ins.first_reg] = mem[ins.address];
               written = mem[ins.address];
            end
            OP_STORE: begin
               mem[ins.address] = regs[ins.first_reg];
               written = regs[ins.first_reg];
            end
            OP_JUMP: begin
               pc = PC_WIDTH'(ins.address);
               advance = 1'b0;
            end
            OP_JZ, OP_JNZ: begin
               if ((ins.op == OP_JZ) == (regs[ins.first_reg] == '0)) begin
                  pc = PC_WIDTH'(ins.address);
                  advance = 1'b0;
               end
            end
            default: begin
               // halt and every unknown opcode
               running = 1'b0;
               advance = 1'b0;
            end
         endcase
         if (advance) pc = pc + PC_STEP;
      end
      r.pc_after      = pc;
      r.stopped       = is_stopped();
      r.value_written = written;
      pending_results.push_back(r);
   endfunction

   function void check_result(exec_result_type got);
      exec_result_type want;
      if (pending_results.size() == 0) begin
         $error("unexpected result beat: pc_after %0d stopped %0d value_written %h",
                got.pc_after, got.stopped, got.value_written);
         mismatches++;
         return;
      end
      want = pending_results.pop_front();
      checked++;
      if (got.pc_after !== want.pc_after) begin
         $error("pc_after: expected %0d, actual %0d", want.pc_after, got.pc_after);
         mismatches++;
      end
      if (got.stopped !== want.stopped) begin
         $error("stopped: expected %0d, actual %0d", want.stopped, got.stopped);
         mismatches++;
      end
      if (got.value_written !== want.value_written) begin
         $error("value_written: expected %h, actual %h", want.value_written,
                got.value_written);
         mismatches++;
      end
   endfunction
endclass

module toy_four_register_cpu_execute_unit_test;

   localparam int RUN_LIMIT_NS = 2_000_000;

   logic clock;
   logic reset;

   tfr_req_if req_chan ();
   tfr_rsp_if rsp_chan ();
   tfr_csr_if csr_chan ();

   execute_tracker tracker;

   // when set, neither side inserts idle cycles
   bit no_idle;
   int length_writes;

   toy_four_register_cpu_execute_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #4 clock = ~clock;

   // build an instruction from explicit fields, for the directed part
   function automatic instr_type make_instr(logic [OP_WIDTH-1:0] op,
                                            logic [REG_IDX_WIDTH-1:0] r1,
                                            logic [REG_IDX_WIDTH-1:0] r2,
                                            logic [ADDR_WIDTH-1:0] addr,
                                            logic [VALUE_WIDTH-1:0] value);
      instr_type ins;
      ins.op           = op;
      ins.first_reg    = r1;
      ins.second_reg   = r2;
      ins.address      = addr;
      ins.preset_value = value;
      return ins;
   endfunction

   // well-formed program traffic: mostly alu and memory work, jump targets kept
   // within 0 to jump_span, capped at 255
   function automatic instr_type random_instr(int jump_span);
      instr_type ins;
      int        pick;
      pick           = $urandom_range(99);
      ins.first_reg  = REG_IDX_WIDTH'($urandom_range(3));
      ins.second_reg = REG_IDX_WIDTH'($urandom_range(3));
      if (pick < 18)      ins.op = OP_ADD;
      else if (pick < 30) ins.op = OP_SUB;
      else if (pick < 44) ins.op = OP_LOAD;
      else if (pick < 58) ins.op = OP_STORE;
      else if (pick < 66) ins.op = OP_JUMP;
      else if (pick < 76) ins.op = OP_JZ;
      else if (pick < 86) ins.op = OP_JNZ;
      else if (pick < 93) ins.op = OP_PRESET_MEM;
      else                ins.op = OP_PRESET_REG;
      if (ins.op == OP_JUMP || ins.op == OP_JZ || ins.op == OP_JNZ)
         ins.address = ADDR_WIDTH'($urandom_range(0, (jump_span > 255) ? 255 : jump_span));
      else if ($urandom_range(1))
         ins.address = ADDR_WIDTH'($urandom_range(0, 15));   // small window so loads hit stores
      else
         ins.address = ADDR_WIDTH'($urandom_range(0, 255));
      case ($urandom_range(7))
         0:       ins.preset_value = '0;
         1:       ins.preset_value = 32'h7fff_ffff;
         2:       ins.preset_value = 32'h8000_0000;
         3:       ins.preset_value = '1;
         4:       ins.preset_value = $urandom_range(0, 3);
         default: ins.preset_value = $urandom;
      endcase
      return ins;
   endfunction

   // drive one instruction beat; entered and left at a falling edge
   task automatic send_instr(instr_type ins);
      if (!no_idle) begin
         // each cycle idles with the same odds, 27 in 100
         while ($urandom_range(99) < 27) begin
            req_chan.valid = 1'b0;
            @(negedge clock);
         end
      end
      req_chan.valid        = 1'b1;
      req_chan.op           = ins.op;
      req_chan.first_reg    = ins.first_reg;
      req_chan.second_reg   = ins.second_reg;
      req_chan.address      = ins.address;
      req_chan.preset_value = ins.preset_value;
      do @(posedge clock); while (!req_chan.ready);
      tracker.note_instruction(ins);
      @(negedge clock);
   endtask

   // stop sending and wait until every predicted result has been checked,
   // then let the two-stage pipe settle
   task automatic drain_results();
      req_chan.valid = 1'b0;
      while (tracker.pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // program_length write, only ever issued with the pipe empty
   task automatic write_length(logic [PLEN_WIDTH-1:0] v);
      drain_results();
      csr_chan.valid = 1'b1;
      csr_chan.data  = v;
      do @(posedge clock); while (!csr_chan.ready);
      tracker.set_length(v);
      length_writes++;
      @(negedge clock);
      csr_chan.valid = 1'b0;
   endtask

   // result side: ready toggles at the falling edge, beats taken at the rising edge
   initial begin
      exec_result_type got;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready = no_idle || ($urandom_range(99) >= 27);
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            got.pc_after      = rsp_chan.pc_after;
            got.stopped       = rsp_chan.stopped;
            got.value_written = rsp_chan.value_written;
            tracker.check_result(got);
         end
      end
   end

   // hard stop in case a handshake never completes
   initial begin
      #RUN_LIMIT_NS;
      $display("FAIL");
      $finish;
   end

   initial begin
      instr_type             ins;
      logic [PLEN_WIDTH-1:0] plen;
      int                    span;

      tracker       = new();
      no_idle       = 1'b0;
      length_writes = 0;

      clock                 = 1'b0;
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.op           = '0;
      req_chan.first_reg    = '0;
      req_chan.second_reg   = '0;
      req_chan.address      = '0;
      req_chan.preset_value = '0;
      csr_chan.valid        = 1'b0;
      csr_chan.data         = '0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // ---- directed part, running on the reset program length ----
      // add of two zero registers straight out of reset
      send_instr(make_instr(OP_ADD, 0, 1, 0, 0));
      // signed extremes into the register file, then wrap both ways
      send_instr(make_instr(OP_PRESET_REG, 0, 0, 0, 32'h7fff_ffff));
      send_instr(make_instr(OP_PRESET_REG, 1, 0, 0, 32'h0000_0001));
      send_instr(make_instr(OP_ADD, 0, 1, 0, 0));
      send_instr(make_instr(OP_PRESET_REG, 2, 0, 0, 32'h8000_0000));
      send_instr(make_instr(OP_SUB, 2, 1, 0, 0));
      // memory at the top address, load it back, store and reload at address zero
      send_instr(make_instr(OP_PRESET_MEM, 0, 0, 255, 32'hffff_ffff));
      send_instr(make_instr(OP_LOAD, 3, 0, 255, 0));
      send_instr(make_instr(OP_STORE, 0, 0, 0, 0));
      send_instr(make_instr(OP_LOAD, 1, 0, 0, 0));
      send_instr(make_instr(OP_ADD, 3, 3, 0, 0));
      send_instr(make_instr(OP_SUB, 1, 1, 0, 0));
      // conditional jumps taken and not taken, then plain jumps to both ends
      send_instr(make_instr(OP_JZ, 1, 0, 200, 0));
      send_instr(make_instr(OP_JNZ, 1, 0, 100, 0));
      send_instr(make_instr(OP_JNZ, 3, 0, 8, 0));
      send_instr(make_instr(OP_JZ, 3, 0, 12, 0));
      send_instr(make_instr(OP_JUMP, 0, 0, 255, 0));
      send_instr(make_instr(OP_JUMP, 0, 0, 0, 0));
      send_instr(make_instr(OP_STORE, 2, 3, 128, 0));

      // zero length program: block is stopped, only the presets still act
      write_length('0);
      send_instr(make_instr(OP_ADD, 0, 1, 0, 0));
      send_instr(make_instr(OP_JUMP, 0, 0, 10, 0));
      send_instr(make_instr(OP_PRESET_MEM, 0, 0, 5, 32'h1234_5678));
      send_instr(make_instr(OP_PRESET_REG, 3, 0, 0, 32'h0000_0000));

      // back to the longest program, then run the counter into a short one
      write_length(PLEN_RESET);
      send_instr(make_instr(OP_LOAD, 0, 0, 5, 0));
      write_length(10'd8);
      send_instr(make_instr(OP_ADD, 2, 2, 0, 0));
      send_instr(make_instr(OP_ADD, 2, 2, 0, 0));

      // ---- random program traffic on the longest program ----
      write_length(PLEN_RESET);
      send_instr(make_instr(OP_JUMP, 0, 0, 0, 0));
      repeat (480) send_instr(random_instr(255));

      // ---- short programs: the counter runs off the end and sticks ----
      for (int k = 0; k < 4; k++) begin
         write_length(PLEN_RESET);
         send_instr(make_instr(OP_JUMP, 0, 0, 0, 0));
         plen = (k == 0) ? 10'd1 : 10'($urandom_range(8, 96));
         span = int'(plen) + 4;
         write_length(plen);
         repeat (60) send_instr(random_instr(span));
      end

      // ---- long run with a no-idle stretch and a full drain in the middle ----
      write_length(PLEN_RESET);
      send_instr(make_instr(OP_JUMP, 0, 0, 0, 0));
      for (int i = 0; i < 500; i++) begin
         no_idle = (i >= 100 && i < 300);
         if (i == 250) drain_results();
         send_instr(random_instr(255));
      end
      no_idle = 1'b0;

      // ---- length somewhere in the middle, program restarted at zero ----
      write_length(PLEN_RESET);
      send_instr(make_instr(OP_JUMP, 0, 0, 0, 0));
      write_length(10'($urandom_range(300, 1022)));
      repeat (250) send_instr(random_instr(255));

      // ---- stop for good: halt or an unknown opcode, then noise on a dead block ----
      write_length(PLEN_RESET);
      ins    = random_instr(255);
      ins.op = OP_WIDTH'($urandom_range(OP_HALT, 15));
      if (ins.op == OP_PRESET_MEM || ins.op == OP_PRESET_REG) ins.op = OP_HALT;
      send_instr(ins);
      repeat (40) begin
         ins    = random_instr(255);
         ins.op = OP_WIDTH'($urandom_range(0, 15));
         send_instr(ins);
      end

      drain_results();
      if (tracker.pending_results.size() != 0) begin
         $error("%0d results never arrived", tracker.pending_results.size());
         tracker.mismatches++;
      end

      $display("run covered %0d instructions over %0d program length settings",
               tracker.executed, length_writes);
      $display("%0d result beats compared, %0d field mismatches",
               tracker.checked, tracker.mismatches);
      if (tracker.mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
